### rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Each check samples on the rising edge of clk and is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define DTHB_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DTHB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dthb_pkg.sv
`default_nettype none
package dthb_pkg;

  localparam int DEPTH_DEFAULT = 256;

  localparam int IN_TDATA_W  = 144;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 144;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 31;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_COMPRESS_RATIO = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SKIP_OFFSET    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_DIST       = 2'd2;

  // Operation codes carried on in_tuser
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Input item as packed on in_tdata, pos_x in the lowest bits
  typedef struct packed {
    logic [6:0]         pad;
    logic [7:0]         history_pos;
    logic               scalar_present;
    logic signed [31:0] scalar_value;
    logic signed [31:0] pos_z;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
  } in_item_t;

  // Result item as packed on out_tdata, accepted in the lowest bit
  typedef struct packed {
    logic [3:0]         pad;
    logic               read_scalar_present;
    logic signed [31:0] read_scalar;
    logic signed [31:0] read_z;
    logic signed [31:0] read_y;
    logic signed [31:0] read_x;
    logic               entry_written;
    logic               entry_in_range;
    logic [7:0]         write_position;
    logic               accepted;
  } out_item_t;

  // One history entry as held in the RAM
  typedef struct packed {
    logic               written;
    logic               scalar_present;
    logic signed [31:0] scalar;
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic rd_issue;
    logic prev_issue;
    logic mul_step;
    logic write;
    logic dec_read;
    logic dec_write;
    logic dec_finish;
    logic clear_step;
    logic res_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_op;
    logic filter_on;
    logic prev_written;
    logic mul_last;
    logic too_close;
    logic need_decim;
    logic src_done;
    logic clear_last;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

### rtl/dthb_ram.sv
`default_nettype none
module dthb_ram #(
  parameter int WIDTH = dthb_pkg::ENTRY_W,
  parameter int DEPTH = dthb_pkg::DEPTH_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/dthb_ctrl.sv
`default_nettype none
module dthb_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire dthb_pkg::stat_t stat,
  output dthb_pkg::cmd_t       cmd
);
  import dthb_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [9:0] {
    S_CLEAR      = 10'b00_0000_0001,
    S_IDLE       = 10'b00_0000_0010,
    S_RD_ISSUE   = 10'b00_0000_0100,
    S_PREV_ISSUE = 10'b00_0000_1000,
    S_PREV_CHECK = 10'b00_0001_0000,
    S_MUL        = 10'b00_0010_0000,
    S_WRITE      = 10'b00_0100_0000,
    S_DEC_RD     = 10'b00_1000_0000,
    S_DEC_WR     = 10'b01_0000_0000,
    S_RESULT     = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          if (stat.in_op == OP_READ) begin
            state_nxt = S_RD_ISSUE;
          end else if (stat.filter_on) begin
            state_nxt = S_PREV_ISSUE;
          end else begin
            state_nxt = S_WRITE;
          end
        end
      end
      S_RD_ISSUE: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_RESULT;
      end
      S_PREV_ISSUE: begin
        cmd.prev_issue = 1'b1;
        state_nxt      = S_PREV_CHECK;
      end
      S_PREV_CHECK: begin
        // an unwritten previous slot always lets the point through
        state_nxt = stat.prev_written ? S_MUL : S_WRITE;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (stat.mul_last) begin
          state_nxt = stat.too_close ? S_RESULT : S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = stat.need_decim ? S_DEC_RD : S_RESULT;
      end
      S_DEC_RD: begin
        if (stat.src_done) begin
          cmd.dec_finish = 1'b1;
          state_nxt      = S_RESULT;
        end else begin
          cmd.dec_read = 1'b1;
          state_nxt    = S_DEC_WR;
        end
      end
      S_DEC_WR: begin
        cmd.dec_write = 1'b1;
        state_nxt     = S_DEC_RD;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `DTHB_ASSERT_NEXT(a_one_item_at_a_time, in_tvalid && in_tready, !in_tready, "accepted a second item while busy")

endmodule
`default_nettype wire

### rtl/dthb_dp.sv
`default_nettype none
module dthb_dp #(
  parameter int DEPTH = dthb_pkg::DEPTH_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire dthb_pkg::cmd_t                 cmd,
  output dthb_pkg::stat_t                     stat,
  // configuration
  input  wire logic                           cfg_we,
  input  wire logic [dthb_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [dthb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input payload
  input  wire logic [dthb_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire logic [dthb_pkg::IN_TUSER_W-1:0] in_tuser,
  // result register
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [dthb_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // RAM
  output logic                                ram_we,
  output logic [$clog2(DEPTH)-1:0]            ram_waddr,
  output logic [dthb_pkg::ENTRY_W-1:0]        ram_wdata,
  output logic                                ram_re,
  output logic [$clog2(DEPTH)-1:0]            ram_raddr,
  input  wire logic [dthb_pkg::ENTRY_W-1:0]   ram_rdata
);
  import dthb_pkg::*;
  `include "assert_macros.svh"

  localparam int AW    = $clog2(DEPTH);
  localparam int NS_W  = $clog2(DEPTH + 1);
  localparam int SW    = $clog2(DEPTH + 256);
  localparam int SUM_W = ((NS_W > 8) ? NS_W : 8) + 1;

  localparam logic [NS_W-1:0]  DEPTH_NS  = NS_W'(DEPTH);
  localparam logic [NS_W-1:0]  LAST_NS   = NS_W'(DEPTH - 1);
  localparam logic [SW-1:0]    DEPTH_SW  = SW'(DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);

  localparam logic [2:0] STEP_X   = 3'd0;
  localparam logic [2:0] STEP_Y   = 3'd1;
  localparam logic [2:0] STEP_Z   = 3'd2;
  localparam logic [2:0] STEP_THR = 3'd3;
  localparam logic [2:0] STEP_CMP = 3'd4;

  // configuration registers
  logic [7:0]        ratio_r;
  logic signed [8:0] skip_r;
  logic [30:0]       min_dist_r;

  // control state
  logic [NS_W-1:0] ns_r;
  logic [NS_W-1:0] dst_r;
  logic [SW-1:0]   src_r;
  logic [2:0]      cnt_r;
  logic            out_valid_r;

  // payload
  in_item_t  item_r;
  logic      op_r;
  logic      keep_r;
  logic      in_range_r;
  logic [63:0] prod_r;
  logic [63:0] acc_r;
  out_item_t out_r;

  in_item_t  in_item;
  entry_t    rd;
  entry_t    wr_entry;
  out_item_t res;

  logic [SUM_W-1:0] hp_ext, ns_ext, ring_sum, ring_slot, rd_slot;
  logic             rd_in_range;
  logic [NS_W-1:0]  prev_slot;
  logic [SW-1:0]    skip_val;
  logic [31:0]      cur_a, cur_b;
  logic [32:0]      diff;
  logic [31:0]      abs_diff;
  logic [31:0]      mul_a;
  logic [63:0]      prod_w;
  logic [64:0]      acc_sum;
  logic             compress;

  assign in_item  = in_item_t'(in_tdata);
  assign rd       = entry_t'(ram_rdata);
  assign compress = (ratio_r != 8'd0);
  assign skip_val = skip_r[8] ? SW'(ratio_r) : SW'(skip_r[7:0]);

  // read slot in history order
  assign hp_ext    = SUM_W'(item_r.history_pos);
  assign ns_ext    = SUM_W'(ns_r);
  assign ring_sum  = ns_ext + hp_ext;
  assign ring_slot = (ring_sum >= DEPTH_SUM) ? (ring_sum - DEPTH_SUM) : ring_sum;
  assign rd_slot   = compress ? hp_ext : ring_slot;
  assign rd_in_range = compress ? (hp_ext < ns_ext) : (hp_ext < DEPTH_SUM);

  assign prev_slot = (ns_r == '0) ? LAST_NS : (ns_r - 1'b1);

  // one component difference per step, then the shared multiplier
  always_comb begin
    case (cnt_r)
      STEP_X: begin
        cur_a = item_r.pos_x;
        cur_b = rd.x;
      end
      STEP_Y: begin
        cur_a = item_r.pos_y;
        cur_b = rd.y;
      end
      default: begin
        cur_a = item_r.pos_z;
        cur_b = rd.z;
      end
    endcase
  end

  assign diff     = {cur_a[31], cur_a} - {cur_b[31], cur_b};
  assign abs_diff = diff[32] ? 32'(~diff + 33'd1) : diff[31:0];
  assign mul_a    = (cnt_r == STEP_THR) ? {1'b0, min_dist_r} : abs_diff;
  assign prod_w   = {32'd0, mul_a} * {32'd0, mul_a};
  assign acc_sum  = {1'b0, acc_r} + {1'b0, prod_r};

  // status
  assign stat.in_op        = in_tuser[0];
  assign stat.filter_on    = (min_dist_r != 31'd0);
  assign stat.prev_written = rd.written;
  assign stat.mul_last     = (cnt_r == STEP_CMP);
  assign stat.too_close    = (acc_r < prod_r);
  assign stat.need_decim   = compress && (ns_r == LAST_NS);
  assign stat.src_done     = (src_r >= DEPTH_SW);
  assign stat.clear_last   = (dst_r == LAST_NS);
  assign stat.out_free     = !out_valid_r || out_tready;

  // RAM ports
  always_comb begin
    wr_entry                = '0;
    wr_entry.written        = 1'b1;
    wr_entry.scalar_present = item_r.scalar_present;
    wr_entry.scalar         = item_r.scalar_value;
    wr_entry.x              = item_r.pos_x;
    wr_entry.y              = item_r.pos_y;
    wr_entry.z              = item_r.pos_z;
  end

  always_comb begin
    ram_we    = cmd.clear_step || cmd.write || cmd.dec_write;
    ram_waddr = dst_r[AW-1:0];
    ram_wdata = '0;
    if (cmd.write) begin
      ram_waddr = ns_r[AW-1:0];
      ram_wdata = wr_entry;
    end else if (cmd.dec_write) begin
      ram_wdata = ram_rdata;
    end
  end

  always_comb begin
    ram_re    = cmd.rd_issue || cmd.prev_issue || cmd.dec_read;
    ram_raddr = src_r[AW-1:0];
    if (cmd.rd_issue) begin
      ram_raddr = rd_slot[AW-1:0];
    end else if (cmd.prev_issue) begin
      ram_raddr = prev_slot[AW-1:0];
    end
  end

  // result word
  always_comb begin
    res                = '0;
    res.write_position = 8'(ns_r);
    if (op_r == OP_READ) begin
      res.entry_in_range = in_range_r;
      if (in_range_r && rd.written) begin
        res.entry_written = 1'b1;
        res.read_x        = rd.x;
        res.read_y        = rd.y;
        res.read_z        = rd.z;
        if (rd.scalar_present) begin
          res.read_scalar         = rd.scalar;
          res.read_scalar_present = 1'b1;
        end
      end
    end else begin
      res.accepted = keep_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r     <= 8'd0;
      skip_r      <= -9'sd1;
      min_dist_r  <= 31'd0;
      ns_r        <= '0;
      dst_r       <= '0;
      src_r       <= '0;
      cnt_r       <= STEP_X;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_COMPRESS_RATIO: ratio_r    <= cfg_wdata[7:0];
          CFG_SKIP_OFFSET:    skip_r     <= cfg_wdata[8:0];
          CFG_MIN_DIST:       min_dist_r <= cfg_wdata;
          default:            ;
        endcase
      end
      cnt_r <= cmd.mul_step ? (cnt_r + 3'd1) : STEP_X;
      // a full decimation leaves the index at the depth itself; fold on next item
      if (cmd.capture && (ns_r >= DEPTH_NS)) begin
        ns_r <= '0;
      end
      if (cmd.write) begin
        if (stat.need_decim) begin
          dst_r <= '0;
          src_r <= skip_val;
        end else begin
          ns_r <= (ns_r == LAST_NS) ? '0 : (ns_r + 1'b1);
        end
      end
      if (cmd.clear_step) begin
        dst_r <= dst_r + 1'b1;
      end
      if (cmd.dec_write) begin
        dst_r <= dst_r + 1'b1;
        src_r <= src_r + SW'(ratio_r);
      end
      if (cmd.dec_finish) begin
        ns_r <= dst_r;
      end
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
      op_r   <= in_tuser[0];
      keep_r <= 1'b0;
    end
    if (cmd.write) begin
      keep_r <= 1'b1;
    end
    if (cmd.rd_issue) begin
      in_range_r <= rd_in_range;
    end
    if (cmd.mul_step) begin
      prod_r <= prod_w;
      case (cnt_r)
        STEP_Y:             acc_r <= prod_r;
        STEP_Z, STEP_THR:   acc_r <= acc_sum[64] ? '1 : acc_sum[63:0];
        default:            ;
      endcase
    end
    if (cmd.res_load) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  `DTHB_ASSERT(a_no_result_overwrite, cmd.res_load, !out_valid_r || out_tready, "result register overwritten")
  `DTHB_ASSERT(a_write_index_folded, cmd.write, ns_r < DEPTH_NS, "store write at unfolded index")
  `DTHB_ASSERT(a_copy_behind_source, cmd.dec_write, SW'(dst_r) <= src_r, "decimation copy overtook its source")

endmodule
`default_nettype wire

### rtl/decimating_trace_history_buffer.sv
`default_nettype none
// Decimating trace history buffer: keeps up to DEPTH 3-D trace points (signed Q16.16) with an
// optional scalar. An add transfer (in_tuser = 0) stores the point at the write index unless
// min_dist is nonzero and the point lies closer than min_dist to the previous stored point;
// a read transfer (in_tuser = 1) returns the entry at a history position, 0 being the oldest.
// With compress_ratio 0 the write index wraps; otherwise filling the last slot decimates the
// store in place and the index becomes the number of entries kept. Each transfer yields one
// result transfer. One item is worked at a time, all through a single RAM with one write and
// one registered read port: a read does one RAM read, an add without the distance filter one
// RAM write, and an add with the filter first reads the previous point, then, if that slot
// was ever written, makes four passes through one shared 32x32 multiplier and a compare
// before the write or the drop. An add that triggers decimation then copies each kept entry
// with a read and a write on the same RAM. A finished result waits in the output register
// while the next item is taken.
// After reset the block runs a clearing pass over every RAM entry before accepting
// items; configuration writes are taken at any time, but must be done while the block is idle.
module decimating_trace_history_buffer #(
  parameter int DEPTH = dthb_pkg::DEPTH_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // configuration: register 0 compress_ratio, 1 skip_offset, 2 min_dist
  input  wire logic                             cfg_we,
  input  wire logic [dthb_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [dthb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // input channel
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // pos_x, pos_y, pos_z, scalar_value, scalar_present, history_pos, zero fill
  input  wire logic [dthb_pkg::IN_TDATA_W-1:0]  in_tdata,
  // op
  input  wire logic [dthb_pkg::IN_TUSER_W-1:0]  in_tuser,
  // result channel
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // accepted, write_position, entry_in_range, entry_written, read_x, read_y, read_z,
  // read_scalar, read_scalar_present, zero fill
  output logic [dthb_pkg::OUT_TDATA_W-1:0]      out_tdata
);
  import dthb_pkg::*;

  localparam int AW = $clog2(DEPTH);

  cmd_t  cmd;
  stat_t stat;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  // sequence each item: capture, RAM reads, filter, store, decimation, result
  dthb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // hold the item, index, counters, distance arithmetic and the result register
  dthb_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  // history store: point, scalar, scalar flag and written flag per entry
  dthb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

endmodule
`default_nettype wire
